// ----- sv/kst_pkg.sv -----
// kst_pkg: shared types, constants and helpers for the knob station tuner
// used by kst_front, kst_fifo, kst_back and knob_station_tuner_unit
package kst_pkg;

  localparam int unsigned DATA_W       = 10;
  localparam int unsigned IDX_W        = 3;
  localparam int unsigned NUM_STATIONS = 6;
  localparam int unsigned MAX_STATIONS = 6;

  localparam logic [DATA_W-1:0] LOCK_CATCH_DIST = 10'd2;
  localparam logic [DATA_W-1:0] LOCK_DROP_DIST  = 10'd8;
  localparam logic [DATA_W-1:0] NEAR_CATCH_DIST = 10'd14;
  localparam logic [DATA_W-1:0] NEAR_DROP_DIST  = 10'd20;
  localparam logic [DATA_W:0]   SWITCH_MARGIN   = 11'd6;

  // register map, index = paddr / 4
  localparam logic [2:0] REG_STATION_COUNT = 3'd0;
  localparam logic [2:0] REG_VALUE_BASE    = 3'd1;

  typedef enum logic [2:0] {
    ST_FAR_BELOW = 3'd0,
    ST_BELOW     = 3'd1,
    ST_TUNED     = 3'd2,
    ST_ABOVE     = 3'd3,
    ST_FAR_ABOVE = 3'd4
  } tune_status_e;

  typedef struct packed {
    logic [IDX_W-1:0]                     count;
    logic [NUM_STATIONS-1:0][DATA_W-1:0]  value;
  } kst_cfg_t;

  function automatic logic [DATA_W-1:0] abs_diff(input logic [DATA_W-1:0] a,
                                                 input logic [DATA_W-1:0] b);
    return (a > b) ? (a - b) : (b - a);
  endfunction

endpackage

// ----- sv/kst_front.sv -----
// kst_front: accepts knob words, keeps the ring window and finds its median
// one candidate per cycle; depends on kst_pkg
module kst_front #(
  parameter int unsigned WINDOW_SIZE = 5
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic [kst_pkg::DATA_W-1:0] reading_i,
  output logic                       push_o,
  output logic [kst_pkg::DATA_W-1:0] med_o,
  input  logic                       full_i
);
  import kst_pkg::*;

  localparam int unsigned WIN_IDX_W = (WINDOW_SIZE > 1) ? $clog2(WINDOW_SIZE) : 1;
  localparam int unsigned CNT_W     = $clog2(WINDOW_SIZE + 1);
  localparam int unsigned MID       = WINDOW_SIZE / 2;

  logic [DATA_W-1:0]    win_q [WINDOW_SIZE];
  logic [WIN_IDX_W-1:0] slot_q, slot_d;
  logic [WIN_IDX_W-1:0] cand_q, cand_d;
  logic                 busy_q, busy_d;

  logic [DATA_W-1:0] cand_val;
  logic [CNT_W-1:0]  less_cnt, le_cnt;
  logic              hit;

  // candidate is the median when at most MID words are below it
  // and more than MID are at or below it
  always_comb begin
    cand_val = win_q[cand_q];
    less_cnt = '0;
    le_cnt   = '0;
    for (int i = 0; i < WINDOW_SIZE; i++) begin
      less_cnt = less_cnt + CNT_W'(win_q[i] < cand_val);
      le_cnt   = le_cnt + CNT_W'(win_q[i] <= cand_val);
    end
    hit = (less_cnt <= CNT_W'(MID)) && (le_cnt > CNT_W'(MID));
  end

  assign in_ready_o = !busy_q;
  assign push_o     = busy_q && hit && !full_i;
  assign med_o      = cand_val;

  always_comb begin
    slot_d = slot_q;
    cand_d = cand_q;
    busy_d = busy_q;
    if (!busy_q) begin
      if (in_valid_i) begin
        slot_d = (slot_q == WIN_IDX_W'(WINDOW_SIZE - 1)) ? '0 : slot_q + 1'b1;
        cand_d = '0;
        busy_d = 1'b1;
      end
    end else if (!hit) begin
      cand_d = cand_q + 1'b1;
    end else if (!full_i) begin
      busy_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_q <= '0;
      cand_q <= '0;
      busy_q <= 1'b0;
      for (int i = 0; i < WINDOW_SIZE; i++) begin
        win_q[i] <= '0;
      end
    end else begin
      slot_q <= slot_d;
      cand_q <= cand_d;
      busy_q <= busy_d;
      if (!busy_q && in_valid_i) begin
        win_q[slot_q] <= reading_i;
      end
    end
  end

endmodule

// ----- sv/kst_fifo.sv -----
// kst_fifo: two-entry queue of medians between front and back
// depends on kst_pkg
module kst_fifo (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       push_i,
  input  logic [kst_pkg::DATA_W-1:0] push_data_i,
  input  logic                       pop_i,
  output logic [kst_pkg::DATA_W-1:0] pop_data_o,
  output logic                       full_o,
  output logic                       empty_o
);
  import kst_pkg::*;

  logic [DATA_W-1:0] mem_q [2];
  logic              wr_q, rd_q;
  logic [1:0]        cnt_q;

  assign full_o     = (cnt_q == 2'd2);
  assign empty_o    = (cnt_q == 2'd0);
  assign pop_data_o = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push_i) begin
        wr_q <= !wr_q;
      end
      if (pop_i) begin
        rd_q <= !rd_q;
      end
      cnt_q <= cnt_q + {1'b0, push_i} - {1'b0, pop_i};
    end
  end

endmodule

// ----- sv/kst_back.sv -----
// kst_back: nearest-station search, station switch and status machine,
// with the output register; depends on kst_pkg
module kst_back (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  kst_pkg::kst_cfg_t           cfg_i,
  input  logic                        empty_i,
  input  logic [kst_pkg::DATA_W-1:0]  med_i,
  output logic                        pop_o,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [kst_pkg::IDX_W-1:0]   out_index_o,
  output logic [2:0]                  out_status_o,
  output logic                        out_has_o,
  output logic [kst_pkg::DATA_W-1:0]  out_med_o
);
  import kst_pkg::*;

  localparam logic [1:0] B_IDLE = 2'd0;
  localparam logic [1:0] B_SCAN = 2'd1;
  localparam logic [1:0] B_DONE = 2'd2;

  logic [1:0]        state_q, state_d;
  logic [IDX_W-1:0]  k_q;
  logic [DATA_W-1:0] med_q;
  logic [DATA_W-1:0] best_q, best_val_q, cur_val_q;
  logic [IDX_W-1:0]  best_ix_q;
  logic [IDX_W-1:0]  tracked_q;
  tune_status_e      status_q;

  logic              out_valid_q;
  logic [IDX_W-1:0]  out_index_q;
  logic [2:0]        out_status_q;
  logic              out_has_q;
  logic [DATA_W-1:0] out_med_q;

  logic [DATA_W-1:0] sv, d;
  logic              in_use;
  logic              out_free;
  logic [DATA_W-1:0] cur_dist, cv;
  logic              sw, above;
  logic [IDX_W-1:0]  tracked_nx;
  tune_status_e      st0, st_nx;

  assign sv       = cfg_i.value[k_q];
  assign d        = abs_diff(sv, med_q);
  assign in_use   = (k_q < cfg_i.count);
  assign out_free = !out_valid_q || out_ready_i;
  assign pop_o    = (state_q == B_IDLE) && !empty_i;

  always_comb begin
    cur_dist   = abs_diff(cur_val_q, med_q);
    sw         = ({1'b0, best_q} + SWITCH_MARGIN) < {1'b0, cur_dist};
    cv         = sw ? best_val_q : cur_val_q;
    tracked_nx = sw ? best_ix_q : tracked_q;
    above      = (med_q > cv);
    if (sw) begin
      // new station's side decides far above or far below
      st0 = (cv >= med_q) ? ST_FAR_ABOVE : ST_FAR_BELOW;
    end else begin
      st0 = status_q;
    end
    st_nx = st0;
    unique case (st0)
      ST_FAR_BELOW, ST_FAR_ABOVE: begin
        if (best_q <= LOCK_CATCH_DIST) begin
          st_nx = ST_TUNED;
        end else if (best_q <= NEAR_CATCH_DIST) begin
          st_nx = above ? ST_ABOVE : ST_BELOW;
        end
      end
      ST_BELOW, ST_ABOVE: begin
        if (best_q >= NEAR_DROP_DIST) begin
          st_nx = above ? ST_FAR_ABOVE : ST_FAR_BELOW;
        end else if (best_q <= LOCK_CATCH_DIST) begin
          st_nx = ST_TUNED;
        end
      end
      ST_TUNED: begin
        if (best_q >= NEAR_DROP_DIST) begin
          st_nx = above ? ST_FAR_ABOVE : ST_FAR_BELOW;
        end else if (best_q >= LOCK_DROP_DIST) begin
          st_nx = above ? ST_ABOVE : ST_BELOW;
        end
      end
      default: st_nx = st0;
    endcase
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      B_IDLE:  if (!empty_i) state_d = B_SCAN;
      B_SCAN:  if (k_q == IDX_W'(NUM_STATIONS - 1)) state_d = B_DONE;
      B_DONE:  if (out_free) state_d = B_IDLE;
      default: state_d = B_IDLE;
    endcase
  end

  // datapath registers, no reset needed
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      med_q <= med_i;
      k_q   <= '0;
    end
    if (state_q == B_SCAN) begin
      k_q <= k_q + 1'b1;
      // ties keep the lower index
      if (in_use && ((k_q == '0) || (d < best_q))) begin
        best_q     <= d;
        best_ix_q  <= k_q;
        best_val_q <= sv;
      end
      if (k_q == tracked_q) begin
        cur_val_q <= sv;
      end
    end
    if ((state_q == B_DONE) && out_free) begin
      out_med_q <= med_q;
      if (cfg_i.count == '0) begin
        out_index_q  <= tracked_q;
        out_status_q <= status_q;
        out_has_q    <= 1'b0;
      end else begin
        out_index_q  <= tracked_nx;
        out_status_q <= st_nx;
        out_has_q    <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= B_IDLE;
      tracked_q   <= '0;
      status_q    <= ST_FAR_BELOW;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if ((state_q == B_DONE) && out_free) begin
        out_valid_q <= 1'b1;
        if (cfg_i.count != '0) begin
          tracked_q <= tracked_nx;
          status_q  <= st_nx;
        end
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_index_o  = out_index_q;
  assign out_status_o = out_status_q;
  assign out_has_o    = out_has_q;
  assign out_med_o    = out_med_q;

endmodule

// ----- sv/knob_station_tuner_unit.sv -----
// knob_station_tuner_unit: top level, register file, front, queue and back
// flow: the front takes a new word only once its median scan of the last word
//   is done; the scan takes one window entry a cycle and holds a found median
//   while the queue is full; the back searches one station a cycle
// reset: rst_ni asynchronous active low; clears window, station tracking,
//   status (far below), station registers and control; datapath is not reset
module knob_station_tuner_unit #(
  parameter int unsigned WINDOW_SIZE = 5
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,  // [9:0] knob_reading
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,  // [2:0] station_index, [5:3] tune_status,
                                     // [15:6] smoothed_reading
  output logic        m_axis_tuser,  // [0] has_station
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import kst_pkg::*;

  logic [2:0]        station_count_q;
  logic [DATA_W-1:0] station_value_q [NUM_STATIONS];
  logic [2:0]        reg_idx;
  logic              reg_wr;
  kst_cfg_t          cfg;

  logic              push, pop, full, empty;
  logic [DATA_W-1:0] push_med, pop_med;
  logic [IDX_W-1:0]  out_index;
  logic [2:0]        out_status;
  logic [DATA_W-1:0] out_med;

  assign pready  = 1'b1;
  assign reg_idx = paddr[4:2];
  assign reg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      station_count_q <= '0;
      for (int j = 0; j < NUM_STATIONS; j++) begin
        station_value_q[j] <= '0;
      end
    end else if (reg_wr) begin
      if (reg_idx == REG_STATION_COUNT) begin
        station_count_q <= pwdata[2:0];
      end
      for (int j = 0; j < NUM_STATIONS; j++) begin
        if (reg_idx == REG_VALUE_BASE + 3'(j)) begin
          station_value_q[j] <= pwdata[DATA_W-1:0];
        end
      end
    end
  end

  always_comb begin
    prdata = '0;
    if (reg_idx == REG_STATION_COUNT) begin
      prdata = {29'd0, station_count_q};
    end
    for (int j = 0; j < NUM_STATIONS; j++) begin
      if (reg_idx == REG_VALUE_BASE + 3'(j)) begin
        prdata = {{(32 - DATA_W){1'b0}}, station_value_q[j]};
      end
    end
  end

  always_comb begin
    cfg.count = (station_count_q > 3'(MAX_STATIONS)) ? 3'(MAX_STATIONS) : station_count_q;
    for (int j = 0; j < NUM_STATIONS; j++) begin
      cfg.value[j] = station_value_q[j];
    end
  end

  kst_front #(
    .WINDOW_SIZE(WINDOW_SIZE)
  ) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(s_axis_tvalid),
    .in_ready_o(s_axis_tready),
    .reading_i (s_axis_tdata[DATA_W-1:0]),
    .push_o    (push),
    .med_o     (push_med),
    .full_i    (full)
  );

  kst_fifo u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_data_i(push_med),
    .pop_i      (pop),
    .pop_data_o (pop_med),
    .full_o     (full),
    .empty_o    (empty)
  );

  kst_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .empty_i     (empty),
    .med_i       (pop_med),
    .pop_o       (pop),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_index_o (out_index),
    .out_status_o(out_status),
    .out_has_o   (m_axis_tuser),
    .out_med_o   (out_med)
  );

  assign m_axis_tdata = {out_med, out_status, out_index};

  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(push && full))
    else $error("median pushed into full queue");

  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(pop && empty))
    else $error("median popped from empty queue");

  a_one_at_front: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("front took a word while its median scan runs");

  a_index_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[2:0] < 3'(MAX_STATIONS)))
    else $error("tracked station index out of range");

endmodule
